[sv/asid_bitmap_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the address-space identifier allocator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASID_BITMAP_ALLOCATOR_MACROS_SVH
`define ASID_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/abal_pkg.sv]
// ----------------------------------------------------------------------------
// abal_pkg
// Shared types and constants of the address-space identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package abal_pkg;

  // Field widths of the request and response.
  localparam int unsigned ASID_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned GEN_W     = 64;

  // The used map is kept as words of this many bits.
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BIT_IDX_W = 6;

  // Defaults and reset values.
  localparam int unsigned      NUM_ASIDS_DEF = 65536;
  localparam logic [ASID_W-1:0] ASID_MAX_RST = 16'hFFFF;
  localparam logic [GEN_W-1:0]  GEN_RST      = 64'd1;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_NEWGEN = 2'd2
  } kind_e;

  // Response status codes.
  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ASID_W-1:0] asid;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [ASID_W-1:0] asid_res;
    logic [GEN_W-1:0]  generation;
  } rsp_t;

endpackage

`default_nettype wire

[sv/asid_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// asid_bitmap_allocator
// Address-space identifier allocator with a used map and generation counter.
// ----------------------------------------------------------------------------
// The used map sits in a single-port-read, single-port-write memory of
// 64-bit words (NUM_ASIDS/64 words, rounded up), and the block serves one
// request at a time. After reset, and after every new-generation request,
// a clearing pass writes one word per cycle over every word of the map,
// during which no request is taken; the new-generation response follows
// that pass. An allocate scans the map one word per cycle from word 0 and
// stops at the first word with a free bit, or after the word that holds
// the usable maximum when none is free. A free issues its word read with
// the request and then passes through a check-and-write-back state and a
// response state. The configuration register is written at once and must
// only change while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module asid_bitmap_allocator #(
  parameter int unsigned NUM_ASIDS = abal_pkg::NUM_ASIDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic [abal_pkg::ASID_W-1:0] cfg_wdata_i,
  // Request channel.
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  abal_pkg::req_t             req_i,
  // Response channel.
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output abal_pkg::rsp_t             rsp_o
);
  import abal_pkg::*;

  `include "asid_bitmap_allocator_macros.svh"

  localparam int unsigned NUM_WORDS = (NUM_ASIDS + WORD_W - 1) / WORD_W;
  localparam int unsigned WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned ID_W      = WAW + BIT_IDX_W;
  localparam logic [ASID_W-1:0] TOP_ID    = ASID_W'(NUM_ASIDS - 1);
  localparam logic [WAW-1:0]    LAST_WORD = WAW'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FCHK  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e             st_q, st_d;
  logic [ASID_W-1:0]  asid_max_q, asid_max_d;
  logic [GEN_W-1:0]   gen_q, gen_d;
  logic [WAW-1:0]     scan_q, scan_d;
  logic               iss_done_q, iss_done_d;
  logic               chk_vld_q, chk_vld_d;
  logic [WAW-1:0]     chk_addr_q, chk_addr_d;
  logic [WAW-1:0]     clr_q, clr_d;
  logic               pend_q, pend_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [ASID_W-1:0]  asid_q, asid_d;
  logic               res_status_q, res_status_d;
  logic [ASID_W-1:0]  res_asid_q, res_asid_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q;

  logic               req_acc;
  logic               rsp_ld;
  logic [ASID_W-1:0]  limit;
  logic [ASID_W-1:0]  limit_shr;
  logic [WAW-1:0]     last_word;
  logic [ASID_W-1:0]  req_shr;
  logic [ASID_W-1:0]  asid_shr;

  logic               mem_we;
  logic [WAW-1:0]     mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WAW-1:0]     mem_raddr;
  logic [WORD_W-1:0]  mem_rdata_q;
  logic [WORD_W-1:0]  map_mem [NUM_WORDS];

  logic                 ff_found;
  logic [BIT_IDX_W-1:0] ff_idx;
  logic [ID_W-1:0]      cand_id;
  logic [ASID_W-1:0]    cand_asid;

  // Usable maximum and the last map word that may hold a grantable identifier.
  assign limit     = (asid_max_q < TOP_ID) ? asid_max_q : TOP_ID;
  assign limit_shr = limit >> BIT_IDX_W;
  assign last_word = limit_shr[WAW-1:0];
  assign req_shr   = req_i.asid >> BIT_IDX_W;
  assign asid_shr  = asid_q >> BIT_IDX_W;

  // Used-map memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= map_mem[mem_raddr];
  end

  // Lowest free identifier of the word under check.
  abal_free_find u_free_find (
    .word_i  (mem_rdata_q),
    .found_o (ff_found),
    .idx_o   (ff_idx)
  );

  assign cand_id   = {chk_addr_q, ff_idx};
  assign cand_asid = ASID_W'(cand_id);

  assign req_ready_o = (st_q == ST_IDLE);
  assign req_acc     = req_valid_i & req_ready_o;
  assign rsp_ld      = (st_q == ST_RESP) & (~rsp_valid_q | rsp_ready_i);

  // Request sequencer: clearing pass, word scan, free check, response.
  always_comb begin
    st_d         = st_q;
    gen_d        = gen_q;
    scan_d       = scan_q;
    iss_done_d   = iss_done_q;
    chk_vld_d    = 1'b0;
    chk_addr_d   = chk_addr_q;
    clr_d        = clr_q;
    pend_d       = pend_q;
    kind_d       = kind_q;
    asid_d       = asid_q;
    res_status_d = res_status_q;
    res_asid_d   = res_asid_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    mem_raddr    = scan_q;

    case (st_q)
      ST_IDLE: begin
        mem_raddr = req_shr[WAW-1:0];
        if (req_acc) begin
          kind_d       = req_i.kind;
          asid_d       = req_i.asid;
          res_asid_d   = '0;
          res_status_d = STATUS_ERR;
          case (req_i.kind)
            KIND_ALLOC: begin
              scan_d     = '0;
              iss_done_d = 1'b0;
              st_d       = ST_SCAN;
            end
            KIND_FREE: begin
              // The word read is issued in this cycle.
              st_d = (req_i.asid > limit) ? ST_RESP : ST_FCHK;
            end
            KIND_NEWGEN: begin
              gen_d        = gen_q + GEN_W'(1);
              res_status_d = STATUS_OK;
              pend_d       = 1'b1;
              clr_d        = '0;
              st_d         = ST_CLEAR;
            end
            default: begin
              st_d = ST_RESP;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_WORD) begin
          clr_d  = '0;
          pend_d = 1'b0;
          st_d   = pend_q ? ST_RESP : ST_IDLE;
        end else begin
          clr_d = clr_q + WAW'(1);
        end
      end

      ST_SCAN: begin
        // Issue the next word read while the previous word is checked.
        if (!iss_done_q) begin
          mem_raddr  = scan_q;
          chk_vld_d  = 1'b1;
          chk_addr_d = scan_q;
          if (scan_q == last_word) begin
            iss_done_d = 1'b1;
          end else begin
            scan_d = scan_q + WAW'(1);
          end
        end
        if (chk_vld_q) begin
          if (ff_found) begin
            if (cand_asid <= limit) begin
              mem_we       = 1'b1;
              mem_waddr    = chk_addr_q;
              mem_wdata    = mem_rdata_q | (WORD_W'(1) << ff_idx);
              res_status_d = STATUS_OK;
              res_asid_d   = cand_asid;
            end
            st_d = ST_RESP;
          end else if (chk_addr_q == last_word) begin
            st_d = ST_RESP;
          end
        end
      end

      ST_FCHK: begin
        if (mem_rdata_q[asid_q[BIT_IDX_W-1:0]]) begin
          mem_we       = 1'b1;
          mem_waddr    = asid_shr[WAW-1:0];
          mem_wdata    = mem_rdata_q & ~(WORD_W'(1) << asid_q[BIT_IDX_W-1:0]);
          res_status_d = STATUS_OK;
        end
        st_d = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_ld) begin
          st_d = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  assign asid_max_d = cfg_we_i ? cfg_wdata_i : asid_max_q;

  // Output slot holds the response until it is taken.
  assign rsp_valid_d = rsp_ld | (rsp_valid_q & ~rsp_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      asid_max_q  <= ASID_MAX_RST;
      gen_q       <= GEN_RST;
      scan_q      <= '0;
      iss_done_q  <= 1'b0;
      chk_vld_q   <= 1'b0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      asid_max_q  <= asid_max_d;
      gen_q       <= gen_d;
      scan_q      <= scan_d;
      iss_done_q  <= iss_done_d;
      chk_vld_q   <= chk_vld_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_addr_q   <= chk_addr_d;
    kind_q       <= kind_d;
    asid_q       <= asid_d;
    res_status_q <= res_status_d;
    res_asid_q   <= res_asid_d;
    if (rsp_ld) begin
      rsp_q.status     <= res_status_q;
      rsp_q.asid_res   <= res_asid_q;
      rsp_q.generation <= gen_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The map is never touched by a request while the clearing pass runs.
  `ABAL_ASSERT_IMP(a_no_req_in_clear, st_q == ST_CLEAR, !req_ready_o,
    "request taken during clearing pass")

  // A granted identifier never exceeds the usable maximum.
  `ABAL_ASSERT_IMP(a_grant_in_range,
    rsp_ld && kind_q == KIND_ALLOC && res_status_q == STATUS_OK,
    res_asid_q <= limit, "granted identifier above usable maximum")

  // The scan never checks a word past the one holding the usable maximum.
  `ABAL_ASSERT_IMP(a_scan_bounded, st_q == ST_SCAN && chk_vld_q,
    chk_addr_q <= last_word, "scan checked a word past the limit")

  // The generation counter moves only on a new-generation request.
  `ABAL_ASSERT_NXT(a_gen_stable, !(req_acc && req_i.kind == KIND_NEWGEN),
    $stable(gen_q), "generation changed without a new-generation request")

  // The map is never written while idle or while a response waits.
  `ABAL_ASSERT_IMP(a_idle_no_write, st_q == ST_IDLE || st_q == ST_RESP, !mem_we,
    "map written outside a request")

endmodule

`default_nettype wire

[sv/abal_free_find.sv]
// ----------------------------------------------------------------------------
// abal_free_find
// Finds the lowest clear bit of one used-map word, in two levels: first the
// lowest byte that holds a clear bit, then the lowest clear bit inside it.
// ----------------------------------------------------------------------------
`default_nettype none

module abal_free_find (
  input  logic [abal_pkg::WORD_W-1:0]    word_i,
  output logic                           found_o,
  output logic [abal_pkg::BIT_IDX_W-1:0] idx_o
);
  import abal_pkg::*;

  localparam int unsigned GRP_W   = 8;
  localparam int unsigned NGRP    = WORD_W / GRP_W;
  localparam int unsigned GRP_IDX = $clog2(NGRP);
  localparam int unsigned SUB_IDX = $clog2(GRP_W);

  logic [NGRP-1:0]    grp_free;
  logic [GRP_IDX-1:0] grp_sel;
  logic [GRP_W-1:0]   grp_word;
  logic [SUB_IDX-1:0] bit_sel;

  // A group holds a free identifier when not all of its bits are set.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free[g] = ~&word_i[g*GRP_W +: GRP_W];
    end
  end

  // Lowest group with a free bit.
  always_comb begin
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_sel = GRP_IDX'(g);
      end
    end
  end

  assign grp_word = word_i[grp_sel*GRP_W +: GRP_W];

  // Lowest clear bit inside the chosen group.
  always_comb begin
    bit_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!grp_word[b]) begin
        bit_sel = SUB_IDX'(b);
      end
    end
  end

  assign found_o = |grp_free;
  assign idx_o   = {grp_sel, bit_sel};

endmodule

`default_nettype wire

[tb/sv/asid_bitmap_allocator_checker.sv]
// ----------------------------------------------------------------------------
// asid_bitmap_allocator_checker
// Watches the request, response and configuration ports of the identifier
// allocator. It keeps its own used map, generation counter and maximum, works
// out the response of every accepted request, and compares each accepted
// response field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module asid_bitmap_allocator_checker #(
  parameter int unsigned NUM_ASIDS = abal_pkg::NUM_ASIDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [abal_pkg::ASID_W-1:0] cfg_wdata_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  abal_pkg::req_t              req_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  abal_pkg::rsp_t              rsp_i,
  output int unsigned                 errors_o,
  output int unsigned                 in_flight_o
);
  import abal_pkg::*;

  // Shadow state of the allocator.
  bit                taken [NUM_ASIDS];
  logic [GEN_W-1:0]  gen_count;
  logic [ASID_W-1:0] max_id;
  rsp_t              awaited_rsps [$];

  // Highest identifier that can be granted or freed right now.
  function automatic int unsigned top_id();
    int unsigned hw_top;
    hw_top = NUM_ASIDS - 1;
    return (int'(max_id) < hw_top) ? int'(max_id) : hw_top;
  endfunction

  // Applies one request to the shadow state and returns its response.
  function automatic rsp_t allocator_outcome(req_t r);
    rsp_t        o;
    int unsigned lim;
    int unsigned id;
    o.status   = STATUS_ERR;
    o.asid_res = '0;
    lim        = top_id();
    case (r.kind)
      KIND_ALLOC: begin
        // The lowest free identifier up to the limit wins.
        id = 0;
        while (id <= lim && taken[id]) id++;
        if (id <= lim) begin
          taken[id]  = 1'b1;
          o.status   = STATUS_OK;
          o.asid_res = ASID_W'(id);
        end
      end
      KIND_FREE: begin
        // Out of range or not marked leaves the map alone.
        if (int'(r.asid) <= lim && taken[r.asid]) begin
          taken[r.asid] = 1'b0;
          o.status      = STATUS_OK;
        end
      end
      KIND_NEWGEN: begin
        gen_count++;
        foreach (taken[i]) taken[i] = 1'b0;
        o.status = STATUS_OK;
      end
      default: begin
        // The unassigned kind is an error with no effect.
      end
    endcase
    o.generation = gen_count;
    return o;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                 input logic [GEN_W-1:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  // Prediction on request handshakes, comparison on response handshakes.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (taken[i]) taken[i] = 1'b0;
      gen_count   = GEN_RST;
      max_id      = ASID_MAX_RST;
      awaited_rsps.delete();
      in_flight_o = 0;
      errors_o    = 0;
    end else begin
      if (cfg_we_i) max_id = cfg_wdata_i;
      if (req_valid_i && req_ready_i) awaited_rsps.push_back(allocator_outcome(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch("response with no request waiting", rsp_i.generation, '0);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.asid_res !== want.asid_res)
            report_mismatch("asid_res", rsp_i.asid_res, want.asid_res);
          if (rsp_i.generation !== want.generation)
            report_mismatch("generation", rsp_i.generation, want.generation);
        end
      end
      in_flight_o = awaited_rsps.size();
    end
  end

endmodule

[tb/sv/asid_bitmap_allocator_test.sv]
// ----------------------------------------------------------------------------
// asid_bitmap_allocator_test
// Stimulus and verdict for the identifier allocator. A short directed run
// covers grants, exhaustion, range and double-free errors, the unassigned
// kind and map flushes; then random phases under several maxima mix mostly
// allocates and frees near the live range with noise, while both channels
// idle at random. A checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module asid_bitmap_allocator_test;
  import abal_pkg::*;

  localparam int unsigned      RESET_CYCLES    = 7;
  localparam int unsigned      QUIET_LIMIT     = 20000;
  localparam int unsigned      DRAIN_CYCLES    = 64;
  localparam int unsigned      CFG_SETTLE      = 8;
  localparam int unsigned      PHASE_COUNT     = 10;
  localparam int unsigned      PHASE_ITEMS     = 68;
  localparam int unsigned      LOW_SPAN        = 160;
  localparam logic [KIND_W-1:0] KIND_UNASSIGNED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ASID_W-1:0] cfg_wdata;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  int unsigned       errors;
  int unsigned       in_flight;
  int unsigned       quiet_cycles = 0;
  int unsigned       stall_left = 0;
  logic [ASID_W-1:0] cur_max = ASID_MAX_RST;
  bit                no_idle = 1'b0;

  asid_bitmap_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  asid_bitmap_allocator_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_valid_i(req_valid),
    .req_ready_i(req_ready),
    .req_i      (req),
    .rsp_valid_i(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_i      (rsp),
    .errors_o   (errors),
    .in_flight_o(in_flight)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Identifier for a free: mostly in and just around the live range.
  function automatic logic [ASID_W-1:0] pick_asid();
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (int'(cur_max) < LOW_SPAN) ? int'(cur_max) + 2 : LOW_SPAN;
    if (r < 80) return ASID_W'($urandom_range(0, span));
    if (r < 88) return cur_max + ASID_W'($urandom_range(0, 1));
    return ASID_W'($urandom());
  endfunction

  // Response side stalls at random.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  // Ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Sends one request after a random gap and waits for its handshake.
  task automatic issue(input logic [KIND_W-1:0] k, input logic [ASID_W-1:0] a);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{kind: k, asid: a};
    do @(posedge clk); while (!req_ready);
  endtask

  // Stops sending and waits until every response has come back.
  task automatic drain(input int unsigned settle);
    @(negedge clk);
    req_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Writes the maximum identifier once the block is idle.
  task automatic set_max(input logic [ASID_W-1:0] v);
    drain(CFG_SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_max   = v;
  endtask

  // One random request: mostly allocates and frees, few flushes.
  task automatic random_item();
    int unsigned       r;
    logic [KIND_W-1:0] k;
    logic [ASID_W-1:0] a;
    r = $urandom_range(0, 99);
    a = ASID_W'($urandom());
    if (r < 48) begin
      k = KIND_ALLOC;
    end else if (r < 94) begin
      k = KIND_FREE;
      a = pick_asid();
    end else if (r < 97) begin
      k = KIND_NEWGEN;
    end else begin
      k = KIND_UNASSIGNED;
    end
    issue(k, a);
  endtask

  function automatic logic [ASID_W-1:0] phase_max(input int unsigned p);
    case (p)
      0:       return 16'hFFFF;
      1:       return 16'd0;
      2:       return 16'd1;
      3:       return 16'd63;
      4:       return 16'd64;
      5:       return 16'd127;
      6:       return 16'd300;
      7:       return ASID_W'($urandom());
      8:       return 16'd2;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Reset, directed checks, random phases and the verdict.
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Grants in order, double free, free of an unused top identifier.
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_ALLOC, 16'hFFFF);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_FREE, 16'd1);
    issue(KIND_FREE, 16'd1);
    issue(KIND_FREE, 16'hFFFF);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_UNASSIGNED, 16'hFFFF);
    issue(KIND_NEWGEN, 16'h0000);
    issue(KIND_FREE, 16'd0);
    issue(KIND_ALLOC, 16'h0000);

    // A small maximum runs out; identifiers past it cannot be freed.
    set_max(16'd1);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_FREE, 16'd2);

    // Lowering the maximum leaves the mark of identifier 1 in place.
    set_max(16'd0);
    issue(KIND_FREE, 16'd1);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_FREE, 16'd0);
    issue(KIND_ALLOC, 16'h0000);
    set_max(16'hFFFF);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_NEWGEN, 16'hFFFF);
    issue(KIND_ALLOC, 16'h0000);
    issue(KIND_ALLOC, 16'h0000);

    // Random phases, one of them without any idling.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      set_max(phase_max(p));
      no_idle = (p == 4);
      repeat (PHASE_ITEMS) random_item();
    end
    no_idle = 1'b0;

    drain(DRAIN_CYCLES);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/abal_pkg.sv
sv/abal_free_find.sv
sv/asid_bitmap_allocator.sv
tb/sv/asid_bitmap_allocator_checker.sv
tb/sv/asid_bitmap_allocator_test.sv
